// ----- rtl/wamg_pkg.sv -----
// ============================================================================
// wamg_pkg
// Shared types and constants for the weighted adjacency matrix graph store.
// ============================================================================
package wamg_pkg;

    // Default table size and fixed field widths.
    localparam int DEF_MAX_VERTICES = 16;
    localparam int KEY_W            = 32;
    localparam int WEIGHT_W         = 16;
    localparam int CMD_W            = 3;
    localparam int STATUS_W         = 2;
    localparam int NIDX_W           = 4;
    localparam int MAX_RES          = 16;
    localparam int RES_CNT_W        = 5;

    // Command codes carried in the input transaction.
    typedef enum logic [CMD_W-1:0] {
        CMD_ADD_VERTEX  = 3'd0,
        CMD_SET_EDGE    = 3'd1,
        CMD_READ_WEIGHT = 3'd2,
        CMD_LIST        = 3'd3,
        CMD_CLEAR_MARKS = 3'd4,
        CMD_MARK        = 3'd5,
        CMD_QUERY_MARK  = 3'd6
    } cmd_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2
    } status_t;

    // One result item without its last flag; status sits in the lowest bits.
    typedef struct packed {
        logic                       is_marked;
        logic [NIDX_W-1:0]          neighbour_index;
        logic [KEY_W-1:0]           neighbour_key;
        logic                       neighbour_valid;
        logic signed [WEIGHT_W-1:0] weight_out;
        logic [STATUS_W-1:0]        status;
    } result_t;

    // One matrix cell: presence flag and stored weight.
    typedef struct packed {
        logic                       present;
        logic signed [WEIGHT_W-1:0] weight;
    } cell_t;

endpackage

// ----- rtl/weighted_adjacency_matrix_graph.sv -----
// ============================================================================
// weighted_adjacency_matrix_graph
// Undirected weighted graph store with key lookup, edge matrix and visit marks.
// ============================================================================
// Each accepted command is decoded in ST_LOOK; set edge writes the mirror cell
// in ST_SYM, read weight returns the cell from ST_RDW, and list reads one column
// per ST_LIST and ST_LCHK pass, holding each neighbour until the next one or
// ST_LEND shows whether it is last. A full result register stalls the sequencer.
// A new command is taken only in ST_IDLE, once the previous one is done. Reset clears
// the count, marks and null weight, then a clearing pass zeroes every matrix cell.
module weighted_adjacency_matrix_graph
    import wamg_pkg::*;
#(
    parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write of null_weight.
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    // Command channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // key_a[31:0], key_b[63:32], weight_in[79:64]
    input  logic [2:0]  s_tuser,   // command[2:0]
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // status[1:0], weight_out[17:2],
                                   // neighbour_valid[18], neighbour_key[50:19],
                                   // neighbour_index[54:51], is_marked[55]
    output logic        m_tlast
);

    localparam int IDX_W     = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CNT_W     = $clog2(MAX_VERTICES + 1);
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int MEM_DEPTH = 1 << ADDR_W;

    typedef enum logic [7:0] {
        ST_CLEAR = 8'b0000_0001,
        ST_IDLE  = 8'b0000_0010,
        ST_LOOK  = 8'b0000_0100,
        ST_SYM   = 8'b0000_1000,
        ST_RDW   = 8'b0001_0000,
        ST_LIST  = 8'b0010_0000,
        ST_LCHK  = 8'b0100_0000,
        ST_LEND  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // Latched command.
    logic [CMD_W-1:0]           cmd_reg;
    logic [KEY_W-1:0]           key_a_reg;
    logic signed [WEIGHT_W-1:0] weight_reg;
    logic [MAX_VERTICES-1:0]    match_a_reg, match_b_reg;

    // Vertex table and marks.
    logic [KEY_W-1:0]        keys_reg [MAX_VERTICES];
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [MAX_VERTICES-1:0] marks_reg, marks_next;
    logic                    key_we;

    // Configuration.
    logic signed [WEIGHT_W-1:0] null_reg;

    // Matrix RAM.
    cell_t             mem [MEM_DEPTH];
    cell_t             rdata_reg;
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    cell_t             mem_wdata;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;

    // Lookup results.
    logic             found_a, found_b;
    logic [IDX_W-1:0] idx_a, idx_b;

    // Neighbour scan.
    logic [IDX_W-1:0]     a_reg, a_next;
    logic [IDX_W-1:0]     b_reg, b_next;
    logic [IDX_W-1:0]     j_reg, j_next;
    logic [RES_CNT_W-1:0] res_cnt_reg, res_cnt_next;
    logic                 held_reg, held_next;
    logic [IDX_W-1:0]     held_idx_reg, held_idx_next;
    logic                 live, end_scan;

    // Output register.
    logic    out_valid_reg, out_last_reg, out_last_next, out_load, out_free;
    result_t out_reg, out_next;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;
    assign m_tlast  = out_last_reg;

    // Lowest matching table index for each key.
    always_comb begin
        found_a = |match_a_reg;
        found_b = |match_b_reg;
        idx_a   = '0;
        idx_b   = '0;
        for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
            if (match_a_reg[i]) begin
                idx_a = IDX_W'(i);
            end
            if (match_b_reg[i]) begin
                idx_b = IDX_W'(i);
            end
        end
    end

    // A cell counts as an edge only while its weight differs from null_weight.
    assign live     = rdata_reg.present && (rdata_reg.weight != null_reg);
    assign end_scan = (CNT_W'(j_reg) == count_reg - CNT_W'(1));

    // Command sequencer.
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        marks_next    = marks_reg;
        key_we        = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = {a_reg, b_reg};
        mem_wdata     = '{present: (weight_reg != null_reg), weight: weight_reg};
        mem_re        = 1'b0;
        mem_raddr     = {a_reg, b_reg};
        clr_addr_next = clr_addr_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        j_next        = j_reg;
        res_cnt_next  = res_cnt_reg;
        held_next     = held_reg;
        held_idx_next = held_idx_reg;
        out_load      = 1'b0;
        out_next      = '0;
        out_last_next = 1'b1;

        unique case (state_reg)
            ST_CLEAR: begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == {ADDR_W{1'b1}}) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: begin
                a_next = idx_a;
                b_next = idx_b;
                case (cmd_reg)
                    CMD_SET_EDGE: begin
                        if (out_free) begin
                            out_load = 1'b1;
                            if (found_a && found_b) begin
                                mem_we     = 1'b1;
                                mem_waddr  = {idx_a, idx_b};
                                state_next = ST_SYM;
                            end else begin
                                out_next.status = STAT_NOT_FOUND;
                                state_next      = ST_IDLE;
                            end
                        end
                    end
                    CMD_READ_WEIGHT: begin
                        if (found_a && found_b) begin
                            mem_re     = 1'b1;
                            mem_raddr  = {idx_a, idx_b};
                            state_next = ST_RDW;
                        end else if (out_free) begin
                            out_load            = 1'b1;
                            out_next.status     = STAT_NOT_FOUND;
                            out_next.weight_out = null_reg;
                            state_next          = ST_IDLE;
                        end
                    end
                    CMD_LIST: begin
                        if (found_a) begin
                            j_next       = '0;
                            res_cnt_next = '0;
                            held_next    = 1'b0;
                            state_next   = ST_LIST;
                        end else if (out_free) begin
                            out_load        = 1'b1;
                            out_next.status = STAT_NOT_FOUND;
                            state_next      = ST_IDLE;
                        end
                    end
                    default: begin
                        if (out_free) begin
                            out_load   = 1'b1;
                            state_next = ST_IDLE;
                            case (cmd_reg)
                                CMD_ADD_VERTEX: begin
                                    if (count_reg == CNT_W'(MAX_VERTICES)) begin
                                        out_next.status = STAT_FULL;
                                    end else begin
                                        key_we     = 1'b1;
                                        marks_next[count_reg[IDX_W-1:0]] = 1'b0;
                                        count_next = count_reg + CNT_W'(1);
                                    end
                                end
                                CMD_CLEAR_MARKS: begin
                                    marks_next = '0;
                                end
                                CMD_MARK: begin
                                    if (found_a) begin
                                        marks_next[idx_a] = 1'b1;
                                    end else begin
                                        out_next.status = STAT_NOT_FOUND;
                                    end
                                end
                                CMD_QUERY_MARK: begin
                                    if (found_a) begin
                                        out_next.is_marked = marks_reg[idx_a];
                                    end else begin
                                        out_next.status = STAT_NOT_FOUND;
                                    end
                                end
                                default: begin
                                end
                            endcase
                        end
                    end
                endcase
            end
            ST_SYM: begin
                // Mirror cell of the edge; a self loop rewrites the same cell.
                mem_we     = 1'b1;
                mem_waddr  = {b_reg, a_reg};
                state_next = ST_IDLE;
            end
            ST_RDW: begin
                if (out_free) begin
                    out_load            = 1'b1;
                    out_next.weight_out = rdata_reg.present ? rdata_reg.weight : null_reg;
                    state_next          = ST_IDLE;
                end
            end
            ST_LIST: begin
                mem_re     = 1'b1;
                mem_raddr  = {a_reg, j_reg};
                state_next = ST_LCHK;
            end
            ST_LCHK: begin
                // A found neighbour is held until the next one shows whether it is last.
                if (!(live && held_reg && !out_free)) begin
                    if (live) begin
                        if (held_reg) begin
                            out_load                 = 1'b1;
                            out_last_next            = 1'b0;
                            out_next.neighbour_valid = 1'b1;
                            out_next.neighbour_key   = keys_reg[held_idx_reg];
                            out_next.neighbour_index = NIDX_W'(held_idx_reg);
                        end
                        held_next     = 1'b1;
                        held_idx_next = j_reg;
                        res_cnt_next  = res_cnt_reg + RES_CNT_W'(1);
                    end
                    if ((live && (res_cnt_reg + RES_CNT_W'(1) == RES_CNT_W'(MAX_RES)))
                            || end_scan) begin
                        state_next = ST_LEND;
                    end else begin
                        j_next     = j_reg + IDX_W'(1);
                        state_next = ST_LIST;
                    end
                end
            end
            ST_LEND: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (held_reg) begin
                        out_next.neighbour_valid = 1'b1;
                        out_next.neighbour_key   = keys_reg[held_idx_reg];
                        out_next.neighbour_index = NIDX_W'(held_idx_reg);
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            count_reg     <= '0;
            marks_reg     <= '0;
            null_reg      <= '0;
            out_valid_reg <= 1'b0;
            held_reg      <= 1'b0;
            res_cnt_reg   <= '0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            count_reg    <= count_next;
            marks_reg    <= marks_next;
            held_reg     <= held_next;
            res_cnt_reg  <= res_cnt_next;
            if (cfg_we) begin
                null_reg <= cfg_wdata;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers and the key compare on command acceptance.
    always_ff @(posedge aclk) begin
        a_reg        <= a_next;
        b_reg        <= b_next;
        j_reg        <= j_next;
        held_idx_reg <= held_idx_next;
        if (out_load) begin
            out_reg      <= out_next;
            out_last_reg <= out_last_next;
        end
        if (key_we) begin
            keys_reg[count_reg[IDX_W-1:0]] <= key_a_reg;
        end
        if (s_tvalid && s_tready) begin
            cmd_reg    <= s_tuser;
            key_a_reg  <= s_tdata[31:0];
            weight_reg <= s_tdata[79:64];
            for (int i = 0; i < MAX_VERTICES; i++) begin
                match_a_reg[i] <= (CNT_W'(i) < count_reg) && (keys_reg[i] == s_tdata[31:0]);
                match_b_reg[i] <= (CNT_W'(i) < count_reg) && (keys_reg[i] == s_tdata[63:32]);
            end
        end
    end

    // Matrix RAM with a registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    // The vertex count never passes the table size.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_VERTICES))
        else $error("vertex count beyond table size");

    // No command is taken while the clearing pass runs.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_tready)
        else $error("command accepted during clearing pass");

    // A list never holds more neighbours than the result limit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        res_cnt_reg <= RES_CNT_W'(MAX_RES))
        else $error("neighbour count beyond result limit");

    // A successful add vertex bumps the count by exactly one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOOK && out_free && cmd_reg == CMD_ADD_VERTEX
            && count_reg != CNT_W'(MAX_VERTICES))
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("vertex count not advanced by add vertex");

    // The matrix RAM is never read and written in the same cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_we && mem_re))
        else $error("matrix read and write overlap");

endmodule

// ----- tb/tb_weighted_adjacency_matrix_graph.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb_weighted_adjacency_matrix_graph
// Self-checking testbench for the weighted adjacency matrix graph store. A
// short table of directed commands runs first. Seeded random traffic follows
// in several phases, each with its own null weight. Every accepted command is
// applied to a behavioral copy of the vertex table, edge matrix and visit
// marks. Each result transaction is compared field by field with the oldest
// outstanding prediction. Both channels idle in random bursts until the last
// phase.
// ============================================================================
module tb_weighted_adjacency_matrix_graph;
    import wamg_pkg::*;

    localparam int         NV          = DEF_MAX_VERTICES;
    localparam logic [2:0] CMD_UNUSED  = 3'd7;
    localparam int         SETTLE_CYC  = 3 + 2 * NV + 8;
    localparam int         QUIET_LIMIT = 4000;
    localparam int         PHASE_ITEMS = 110;

    // One row of the directed command table.
    typedef struct {
        logic [2:0]         cmd;
        logic [31:0]        key_a;
        logic [31:0]        key_b;
        logic signed [15:0] weight;
        bit                 pinned;
        status_t            status;
        logic signed [15:0] weight_out;
        bit                 marked;
    } stim_row_t;

    // One predicted result transaction.
    typedef struct {
        result_t fields;
        logic    last;
    } graph_reply_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata   = '0;   // key_a[31:0], key_b[63:32], weight_in[79:64]
    logic [2:0]  s_tuser   = '0;   // command[2:0]
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [55:0] m_tdata;          // status[1:0], weight_out[17:2], neighbour_valid[18],
                                   // neighbour_key[50:19], neighbour_index[54:51],
                                   // is_marked[55]
    logic        m_tlast;

    // Behavioral copy of the graph state.
    logic [31:0]        vtx_key [NV];
    int                 vtx_count;
    bit                 edge_on [NV*NV];
    logic signed [15:0] edge_w  [NV*NV];
    bit                 visited [NV];
    logic signed [15:0] null_w;

    graph_reply_t replies_due[$];
    stim_row_t    directed_rows [25];
    int           error_count;
    int           stall_left;
    int           quiet_cycles;
    bit           send_gaps   = 1'b1;
    bit           sink_stalls = 1'b1;

    weighted_adjacency_matrix_graph #(
        .MAX_VERTICES(NV)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #5 aclk = ~aclk;

    // Lowest table index holding the key, among the vertices added so far.
    function automatic bit find_vertex(input logic [31:0] key, output int idx);
        idx = 0;
        for (int i = 0; i < vtx_count; i++) begin
            if (vtx_key[i] == key) begin
                idx = i;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void push_reply(input status_t st, input logic signed [15:0] w,
                                       input logic valid, input logic [31:0] nkey,
                                       input logic [3:0] nidx, input logic marked,
                                       input logic last);
        graph_reply_t rep;
        rep.fields.status          = st;
        rep.fields.weight_out      = w;
        rep.fields.neighbour_valid = valid;
        rep.fields.neighbour_key   = nkey;
        rep.fields.neighbour_index = nidx;
        rep.fields.is_marked       = marked;
        rep.last                   = last;
        replies_due.push_back(rep);
    endfunction

    // Apply one accepted command to the graph copy and queue its results.
    function automatic void apply_graph_command(input logic [2:0] cmd,
                                                input logic [31:0] ka,
                                                input logic [31:0] kb,
                                                input logic signed [15:0] w);
        int           a;
        int           b;
        int           slot;
        int           n;
        bit           found_a;
        bit           found_b;
        graph_reply_t tail;
        found_a = find_vertex(ka, a);
        found_b = find_vertex(kb, b);
        case (cmd)
            CMD_ADD_VERTEX: begin
                if (vtx_count >= NV) begin
                    push_reply(STAT_FULL, '0, 1'b0, '0, '0, 1'b0, 1'b1);
                end else begin
                    vtx_key[vtx_count] = ka;
                    visited[vtx_count] = 1'b0;
                    vtx_count++;
                    push_reply(STAT_OK, '0, 1'b0, '0, '0, 1'b0, 1'b1);
                end
            end
            CMD_SET_EDGE: begin
                if (!(found_a && found_b)) begin
                    push_reply(STAT_NOT_FOUND, '0, 1'b0, '0, '0, 1'b0, 1'b1);
                end else begin
                    // A weight equal to the null value removes the edge.
                    edge_on[a*NV + b] = (w != null_w);
                    edge_on[b*NV + a] = (w != null_w);
                    edge_w[a*NV + b]  = w;
                    edge_w[b*NV + a]  = w;
                    push_reply(STAT_OK, '0, 1'b0, '0, '0, 1'b0, 1'b1);
                end
            end
            CMD_READ_WEIGHT: begin
                if (!(found_a && found_b)) begin
                    push_reply(STAT_NOT_FOUND, null_w, 1'b0, '0, '0, 1'b0, 1'b1);
                end else begin
                    slot = a*NV + b;
                    push_reply(STAT_OK, edge_on[slot] ? edge_w[slot] : null_w,
                               1'b0, '0, '0, 1'b0, 1'b1);
                end
            end
            CMD_LIST: begin
                if (!found_a) begin
                    push_reply(STAT_NOT_FOUND, '0, 1'b0, '0, '0, 1'b0, 1'b1);
                end else begin
                    // Stored weights that now equal the null value count as absent.
                    n = 0;
                    for (int j = 0; j < vtx_count && n < MAX_RES; j++) begin
                        slot = a*NV + j;
                        if (edge_on[slot] && edge_w[slot] != null_w) begin
                            push_reply(STAT_OK, '0, 1'b1, vtx_key[j], 4'(j), 1'b0, 1'b0);
                            n++;
                        end
                    end
                    if (n == 0) begin
                        push_reply(STAT_OK, '0, 1'b0, '0, '0, 1'b0, 1'b1);
                    end else begin
                        tail      = replies_due.pop_back();
                        tail.last = 1'b1;
                        replies_due.push_back(tail);
                    end
                end
            end
            CMD_CLEAR_MARKS: begin
                for (int i = 0; i < NV; i++) begin
                    visited[i] = 1'b0;
                end
                push_reply(STAT_OK, '0, 1'b0, '0, '0, 1'b0, 1'b1);
            end
            CMD_MARK: begin
                if (!found_a) begin
                    push_reply(STAT_NOT_FOUND, '0, 1'b0, '0, '0, 1'b0, 1'b1);
                end else begin
                    visited[a] = 1'b1;
                    push_reply(STAT_OK, '0, 1'b0, '0, '0, 1'b0, 1'b1);
                end
            end
            CMD_QUERY_MARK: begin
                if (!found_a) begin
                    push_reply(STAT_NOT_FOUND, '0, 1'b0, '0, '0, 1'b0, 1'b1);
                end else begin
                    push_reply(STAT_OK, '0, 1'b0, '0, '0, visited[a], 1'b1);
                end
            end
            default: begin
                push_reply(STAT_OK, '0, 1'b0, '0, '0, 1'b0, 1'b1);
            end
        endcase
    endfunction

    function automatic logic [31:0] stored_key();
        return vtx_key[$urandom_range(0, vtx_count - 1)];
    endfunction

    // Present one command and hold it until the block takes the transaction.
    task automatic send_command(input logic [2:0] cmd, input logic [31:0] ka,
                                input logic [31:0] kb, input logic signed [15:0] w);
        if (send_gaps && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {w, kb, ka};
        s_tuser  <= cmd;
        @(posedge aclk);
        while (s_tready !== 1'b1) @(posedge aclk);
        apply_graph_command(cmd, ka, kb, w);
    endtask

    // Stop sending and wait until every predicted result has come back.
    task automatic drain_replies();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (replies_due.size() != 0) @(posedge aclk);
    endtask

    task automatic write_null_weight(input logic signed [15:0] value);
        drain_replies();
        repeat (SETTLE_CYC) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        null_w = value;
    endtask

    // Mostly well-formed commands on stored keys, with some raw noise.
    task automatic send_random_command();
        logic [2:0]         cmd;
        logic [31:0]        ka;
        logic [31:0]        kb;
        logic signed [15:0] w;
        int                 pick;
        ka   = $urandom;
        kb   = $urandom;
        w    = 16'($urandom);
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 7))
            0: w = null_w;
            1: w = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            default: ;
        endcase
        if (pick < 10) begin
            cmd = 3'($urandom_range(0, 7));
        end else begin
            ka = stored_key();
            kb = stored_key();
            if (pick < 18) begin
                cmd = CMD_ADD_VERTEX;
                if ($urandom_range(0, 3) != 0) begin
                    ka = $urandom;
                end
            end else if (pick < 50) begin
                cmd = CMD_SET_EDGE;
            end else if (pick < 62) begin
                cmd = CMD_READ_WEIGHT;
            end else if (pick < 76) begin
                cmd = CMD_LIST;
            end else if (pick < 84) begin
                cmd = CMD_MARK;
            end else if (pick < 92) begin
                cmd = CMD_QUERY_MARK;
            end else if (pick < 96) begin
                cmd = CMD_CLEAR_MARKS;
            end else begin
                cmd = CMD_UNUSED;
            end
        end
        send_command(cmd, ka, kb, w);
    endtask

    // Fill the table, link one vertex to every vertex and itself, list it, then add one too many.
    task automatic send_star();
        int                 hub;
        int                 dummy;
        logic [31:0]        fresh;
        logic signed [15:0] w;
        while (vtx_count < NV) begin
            fresh = $urandom;
            if (!find_vertex(fresh, dummy)) begin
                send_command(CMD_ADD_VERTEX, fresh, '0, '0);
            end
        end
        hub = $urandom_range(0, NV - 1);
        for (int j = 0; j < NV; j++) begin
            do begin
                w = 16'($urandom);
            end while (w == null_w);
            send_command(CMD_SET_EDGE, vtx_key[hub], vtx_key[j], w);
        end
        send_command(CMD_LIST, vtx_key[hub], '0, '0);
        send_command(CMD_ADD_VERTEX, $urandom, '0, '0);
    endtask

    // Result checking against the oldest prediction.
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin
        graph_reply_t want;
        result_t      got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (replies_due.size() == 0) begin
                $display("%0t: unexpected result transaction, expected none, actual 0x%0h last %0b",
                         $time, m_tdata, m_tlast);
                error_count++;
            end else begin
                want = replies_due.pop_front();
                check_field("status", 32'(want.fields.status), 32'(got.status));
                check_field("weight_out", 32'(16'(want.fields.weight_out)),
                            32'(16'(got.weight_out)));
                check_field("neighbour_valid", 32'(want.fields.neighbour_valid),
                            32'(got.neighbour_valid));
                check_field("neighbour_key", want.fields.neighbour_key, got.neighbour_key);
                check_field("neighbour_index", 32'(want.fields.neighbour_index),
                            32'(got.neighbour_index));
                check_field("is_marked", 32'(want.fields.is_marked), 32'(got.is_marked));
                check_field("last", 32'(want.last), 32'(m_tlast));
            end
        end
    end

    // Result-side backpressure in random bursts.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 13);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_weighted_adjacency_matrix_graph: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic signed [15:0] phase_null;
        null_w      = '0;
        vtx_count   = 0;
        error_count = 0;
        // Results are typed in only on pinned rows; the rest use the prediction.
        directed_rows = '{
            '{CMD_QUERY_MARK,  32'h0000_0000, 32'h0000_0000, 16'sh0000, 1'b1, STAT_NOT_FOUND, 16'sh0000, 1'b0},
            '{CMD_LIST,        32'h0000_0005, 32'h0000_0000, 16'sh0000, 1'b1, STAT_NOT_FOUND, 16'sh0000, 1'b0},
            '{CMD_READ_WEIGHT, 32'h0000_0001, 32'h0000_0002, 16'sh0000, 1'b1, STAT_NOT_FOUND, 16'sh0000, 1'b0},
            '{CMD_ADD_VERTEX,  32'h0000_0000, 32'h0000_0000, 16'sh0000, 1'b1, STAT_OK,        16'sh0000, 1'b0},
            '{CMD_ADD_VERTEX,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'shFFFF, 1'b1, STAT_OK,        16'sh0000, 1'b0},
            '{CMD_ADD_VERTEX,  32'h0000_1234, 32'h0000_0000, 16'sh0000, 1'b1, STAT_OK,        16'sh0000, 1'b0},
            '{CMD_ADD_VERTEX,  32'h0000_0000, 32'h0000_0000, 16'sh0000, 1'b1, STAT_OK,        16'sh0000, 1'b0},
            '{CMD_SET_EDGE,    32'h0000_0000, 32'hFFFF_FFFF, 16'sh7FFF, 1'b1, STAT_OK,        16'sh0000, 1'b0},
            '{CMD_SET_EDGE,    32'hFFFF_FFFF, 32'h0000_1234, 16'sh8000, 1'b1, STAT_OK,        16'sh0000, 1'b0},
            '{CMD_SET_EDGE,    32'h0000_1234, 32'h0000_1234, 16'sh0005, 1'b1, STAT_OK,        16'sh0000, 1'b0},
            '{CMD_READ_WEIGHT, 32'h0000_0000, 32'hFFFF_FFFF, 16'sh0000, 1'b1, STAT_OK,        16'sh7FFF, 1'b0},
            '{CMD_READ_WEIGHT, 32'h0000_1234, 32'hFFFF_FFFF, 16'sh0000, 1'b1, STAT_OK,        16'sh8000, 1'b0},
            '{CMD_LIST,        32'hFFFF_FFFF, 32'h0000_0000, 16'sh0000, 1'b0, STAT_OK,        16'sh0000, 1'b0},
            '{CMD_LIST,        32'h0000_1234, 32'h0000_0000, 16'sh0000, 1'b0, STAT_OK,        16'sh0000, 1'b0},
            '{CMD_SET_EDGE,    32'h0000_0000, 32'h0000_1234, 16'shFFFF, 1'b0, STAT_OK,        16'sh0000, 1'b0},
            '{CMD_LIST,        32'h0000_0000, 32'h0000_0000, 16'sh0000, 1'b0, STAT_OK,        16'sh0000, 1'b0},
            '{CMD_SET_EDGE,    32'h0000_1234, 32'h0000_0000, 16'sh0000, 1'b0, STAT_OK,        16'sh0000, 1'b0},
            '{CMD_READ_WEIGHT, 32'h0000_0000, 32'h0000_1234, 16'sh0000, 1'b0, STAT_OK,        16'sh0000, 1'b0},
            '{CMD_SET_EDGE,    32'h0000_0000, 32'h0000_0099, 16'sh0003, 1'b1, STAT_NOT_FOUND, 16'sh0000, 1'b0},
            '{CMD_MARK,        32'hFFFF_FFFF, 32'h0000_0000, 16'sh0000, 1'b0, STAT_OK,        16'sh0000, 1'b0},
            '{CMD_QUERY_MARK,  32'hFFFF_FFFF, 32'h0000_0000, 16'sh0000, 1'b1, STAT_OK,        16'sh0000, 1'b1},
            '{CMD_CLEAR_MARKS, 32'h0000_0000, 32'h0000_0000, 16'sh0000, 1'b1, STAT_OK,        16'sh0000, 1'b0},
            '{CMD_QUERY_MARK,  32'hFFFF_FFFF, 32'h0000_0000, 16'sh0000, 1'b0, STAT_OK,        16'sh0000, 1'b0},
            '{CMD_MARK,        32'h0000_0099, 32'h0000_0000, 16'sh0000, 1'b1, STAT_NOT_FOUND, 16'sh0000, 1'b0},
            '{CMD_UNUSED,      32'h0000_0000, 32'h0000_0000, 16'sh0000, 1'b1, STAT_OK,        16'sh0000, 1'b0}
        };

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed commands at the reset null weight.
        foreach (directed_rows[i]) begin
            send_command(directed_rows[i].cmd, directed_rows[i].key_a,
                         directed_rows[i].key_b, directed_rows[i].weight);
            if (directed_rows[i].pinned) begin
                void'(replies_due.pop_back());
                push_reply(directed_rows[i].status, directed_rows[i].weight_out, 1'b0,
                           '0, '0, directed_rows[i].marked, 1'b1);
            end
        end

        // Largest null weight, with one full drain halfway through.
        write_null_weight(16'sh7FFF);
        for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i == PHASE_ITEMS / 2) begin
                drain_replies();
            end
            send_random_command();
        end

        // Smallest null weight, with a full table and a long neighbour list.
        write_null_weight(16'sh8000);
        send_star();
        for (int i = 0; i < PHASE_ITEMS; i++) begin
            send_random_command();
        end

        // Null weight taken from a stored edge where one is picked, else random, so that edge turns absent.
        phase_null = 16'($urandom);
        for (int c = 0; c < NV*NV; c++) begin
            if (edge_on[c] && $urandom_range(0, 3) == 0) begin
                phase_null = edge_w[c];
            end
        end
        write_null_weight(phase_null);
        for (int i = 0; i < PHASE_ITEMS; i++) begin
            send_random_command();
        end

        // Back to zero, both sides at full rate.
        send_gaps   <= 1'b0;
        sink_stalls <= 1'b0;
        write_null_weight(16'sh0000);
        for (int i = 0; i < PHASE_ITEMS; i++) begin
            send_random_command();
        end

        drain_replies();
        repeat (SETTLE_CYC) @(posedge aclk);
        if (error_count == 0) begin
            $display("tb_weighted_adjacency_matrix_graph: clean");
        end else begin
            $display("tb_weighted_adjacency_matrix_graph: errors");
        end
        $finish;
    end

endmodule
